[hdl/ozrc_pkg.sv]
package ozrc_pkg;

    // digit steps of the square root and quotient bits of the divider
    localparam int SQRT_STEPS = 32;
    localparam int QUO_BITS   = 17;

    typedef enum logic [3:0] {
        REG_ZERO_ENABLE = 4'd0,
        REG_INV_QX      = 4'd1,
        REG_INV_QY      = 4'd2,
        REG_INV_QZ      = 4'd3,
        REG_INV_QW      = 4'd4,
        REG_ZERO_ROLL   = 4'd5,
        REG_ZERO_PITCH  = 4'd6,
        REG_ZERO_YAW    = 4'd7
    } ozrc_reg_t;

    // fields that ride alongside the arithmetic; lane order x, y, z, w
    typedef struct packed {
        logic             en;
        logic             zero;
        logic [3:0]       neg;   // sign of each product lane
        logic [3:0][15:0] pq;
        logic [2:0][15:0] ang;
    } ozrc_side_t;

    typedef struct packed {
        ozrc_side_t       side;
        logic [3:0][31:0] u;
    } ozrc_carry_t;

    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        logic [15:0] r;
        if (v > 18'sd32767)
            r = 16'h7fff;
        else if (v < -18'sd32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

[hdl/ozrc_qmul.sv]
module ozrc_qmul
    import ozrc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    en,
    input  logic [3:0][15:0]        a,
    input  logic [3:0][15:0]        b,
    input  logic [2:0][15:0]        ang,
    input  logic [2:0][15:0]        zero_ang,
    output logic                    out_valid,
    output logic [3:0][33:0]        v,
    output ozrc_side_t              side
);

    logic signed [31:0] p_reg [4][4];
    ozrc_side_t         side1_reg;
    ozrc_side_t         side1_next;
    logic               vld1_reg;
    logic [3:0][33:0]   v_reg;
    logic [3:0][33:0]   v_next;
    ozrc_side_t         side2_reg;
    logic               vld2_reg;

    function automatic logic signed [33:0] ext(input logic signed [31:0] p);
        return 34'(p);
    endfunction

    always_comb
    begin
        logic signed [17:0] d;
        side1_next      = '0;
        side1_next.en   = en;
        side1_next.pq   = b;
        for (int k = 0; k < 3; k++)
        begin
            d = 18'($signed(ang[k])) - 18'($signed(zero_ang[k]));
            side1_next.ang[k] = en ? sat16(d) : ang[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                p_reg[i][j] <= $signed(a[i]) * $signed(b[j]);
        side1_reg <= side1_next;
    end

    // hamilton product a * b
    always_comb
    begin
        v_next[0] = ext(p_reg[3][0]) + ext(p_reg[0][3]) + ext(p_reg[1][2]) - ext(p_reg[2][1]);
        v_next[1] = ext(p_reg[3][1]) - ext(p_reg[0][2]) + ext(p_reg[1][3]) + ext(p_reg[2][0]);
        v_next[2] = ext(p_reg[3][2]) + ext(p_reg[0][1]) - ext(p_reg[1][0]) + ext(p_reg[2][3]);
        v_next[3] = ext(p_reg[3][3]) - ext(p_reg[0][0]) - ext(p_reg[1][1]) - ext(p_reg[2][2]);
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        side2_reg <= side1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    assign out_valid = vld2_reg;
    assign v         = v_reg;
    assign side      = side2_reg;

endmodule

[hdl/ozrc_norm.sv]
module ozrc_norm
    import ozrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [3:0][33:0] v,
    input  ozrc_side_t       side_in,
    output logic             out_valid,
    output logic [62:0]      n,
    output ozrc_carry_t      carry
);

    logic [6:0]       vld_reg;
    ozrc_side_t       side_reg [7];
    ozrc_side_t       side1_next;
    logic [3:0][31:0] w1_reg, w1_next;
    logic [3:0][31:0] w2_reg;
    logic [30:0]      x_reg, x_next;
    logic [3:0][31:0] w3_reg;
    logic [4:0]       l_reg, l_next;
    logic [3:0][31:0] u4_reg, u5_reg, u6_reg, u7_reg;
    logic [60:0]      sq_reg [4];
    logic [61:0]      s01_reg, s23_reg;
    logic [62:0]      n_reg;

    // right shift by the fewest halvings that bring every lane within 2^30
    always_comb
    begin
        logic signed [33:0] sh [3][4];
        logic [33:0]        mg;
        logic [2:0]         ok;
        ok = 3'b111;
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 4; i++)
            begin
                sh[k][i] = $signed(v[i]) >>> k;
                mg       = sh[k][i][33] ? 34'(-sh[k][i]) : 34'(sh[k][i]);
                if (mg > 34'd1073741824)
                    ok[k] = 1'b0;
            end
        for (int i = 0; i < 4; i++)
            w1_next[i] = ok[0] ? sh[0][i][31:0] : (ok[1] ? sh[1][i][31:0] : sh[2][i][31:0]);
        side1_next      = side_in;
        side1_next.zero = (v == '0);
    end

    // or of (magnitude - 1) has the bit length of (max magnitude - 1)
    always_comb
    begin
        logic [31:0] mw;
        x_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            mw = w1_reg[i][31] ? 32'(-$signed(w1_reg[i])) : w1_reg[i];
            if (mw != '0)
                x_next = x_next | 31'(mw - 32'd1);
        end
    end

    // left shift count: 30 minus the bit length
    always_comb
    begin
        logic [4:0] bl;
        bl = '0;
        for (int b = 0; b < 31; b++)
            if (x_reg[b])
                bl = 5'(b + 1);
        l_next = 5'd30 - bl;
    end

    always_ff @(posedge clk)
    begin
        w1_reg   <= w1_next;
        w2_reg   <= w1_reg;
        x_reg    <= x_next;
        w3_reg   <= w2_reg;
        l_reg    <= l_next;
        for (int i = 0; i < 4; i++)
            u4_reg[i] <= w3_reg[i] << l_reg;
        for (int i = 0; i < 4; i++)
        begin
            logic signed [63:0] pr;
            pr = $signed(u4_reg[i]) * $signed(u4_reg[i]);
            sq_reg[i] <= pr[60:0];
        end
        u5_reg   <= u4_reg;
        s01_reg  <= {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
        s23_reg  <= {1'b0, sq_reg[2]} + {1'b0, sq_reg[3]};
        u6_reg   <= u5_reg;
        n_reg    <= {1'b0, s01_reg} + {1'b0, s23_reg};
        u7_reg   <= u6_reg;
        side_reg[0] <= side1_next;
        for (int s = 1; s < 7; s++)
            side_reg[s] <= side_reg[s-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[5:0], in_valid};
    end

    assign out_valid  = vld_reg[6];
    assign n          = n_reg;
    assign carry.side = side_reg[6];
    assign carry.u    = u7_reg;

`ifndef SYNTHESIS
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !carry.side.zero |-> n >= 63'h0400_0000_0000_0000
            && n <= 63'h4000_0000_0000_0000)
        else $error("scaled norm out of range");
`endif

endmodule

[hdl/ozrc_isqrt.sv]
module ozrc_isqrt
    import ozrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [62:0] n,
    input  ozrc_carry_t carry_in,
    output logic        out_valid,
    output logic [31:0] root,
    output ozrc_carry_t carry_out
);

    logic [SQRT_STEPS-1:0] vld_reg;
    logic [33:0]           rem_reg  [SQRT_STEPS];
    logic [31:0]           root_reg [SQRT_STEPS];
    logic [63:0]           n_reg    [SQRT_STEPS];
    ozrc_carry_t           car_reg  [SQRT_STEPS];

    // one result bit per stage, two radicand bits brought down each time
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam int P = SQRT_STEPS - 1 - k;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] n_in;
        ozrc_carry_t car_in;
        logic [35:0] acc, trial;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = {1'b0, n};
            assign car_in  = carry_in;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign n_in    = n_reg[k-1];
            assign car_in  = car_reg[k-1];
        end

        assign acc   = {rem_in, n_in[2*P+1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (acc >= trial)
            begin
                rem_reg[k]  <= 34'(acc - trial);
                root_reg[k] <= {root_in[30:0], 1'b1};
            end
            else
            begin
                rem_reg[k]  <= acc[33:0];
                root_reg[k] <= {root_in[30:0], 1'b0};
            end
            n_reg[k]   <= n_in;
            car_reg[k] <= car_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[SQRT_STEPS-2:0], in_valid};
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign root      = root_reg[SQRT_STEPS-1];
    assign carry_out = car_reg[SQRT_STEPS-1];

`ifndef SYNTHESIS
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({34'd0, root} * {34'd0, root} <= {2'b00, n_reg[SQRT_STEPS-1]})
            && ({34'd0, root} + 66'd1) * ({34'd0, root} + 66'd1)
               > {2'b00, n_reg[SQRT_STEPS-1]})
        else $error("root is not the floor square root");
`endif

endmodule

[hdl/ozrc_div.sv]
module ozrc_div
    import ozrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [31:0]      s,
    input  ozrc_carry_t      carry,
    output logic             out_valid,
    output logic [3:0][15:0] q,
    output logic [2:0][15:0] ang
);

    logic                vld0_reg;
    logic [32:0]         d0_reg;
    logic [46:0]         dv0_reg [4];
    ozrc_side_t          side0_reg;
    logic [QUO_BITS-1:0] vld_reg;
    logic [46:0]         rem_reg [QUO_BITS][4];
    logic [QUO_BITS-1:0] quo_reg [QUO_BITS][4];
    logic [32:0]         d_reg   [QUO_BITS];
    ozrc_side_t          side_reg[QUO_BITS];
    logic                vldo_reg;
    logic [3:0][15:0]    q_reg, q_next;
    logic [2:0][15:0]    ang_reg;

    // dividend |u| * 2^15 + s over divisor 2s rounds half away from zero
    always_ff @(posedge clk)
    begin
        logic [31:0] mu;
        ozrc_side_t  sd0;
        sd0 = carry.side;
        for (int i = 0; i < 4; i++)
        begin
            mu = carry.u[i][31] ? 32'(-$signed(carry.u[i])) : carry.u[i];
            dv0_reg[i] <= {1'b0, mu[30:0], 15'd0} + {15'd0, s};
            sd0.neg[i] = carry.u[i][31];
        end
        d0_reg    <= {s, 1'b0};
        side0_reg <= sd0;
    end

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_bit
        localparam int J = QUO_BITS - 1 - k;
        logic [46:0]         rem_in [4];
        logic [QUO_BITS-1:0] quo_in [4];
        logic [32:0]         d_in;
        ozrc_side_t          side_in;
        logic [49:0]         dsh;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < 4; i++)
                begin
                    rem_in[i] = dv0_reg[i];
                    quo_in[i] = '0;
                end
            end
            assign d_in    = d0_reg;
            assign side_in = side0_reg;
        end
        else
        begin : g_next
            always_comb
            begin
                for (int i = 0; i < 4; i++)
                begin
                    rem_in[i] = rem_reg[k-1][i];
                    quo_in[i] = quo_reg[k-1][i];
                end
            end
            assign d_in    = d_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign dsh = {17'd0, d_in} << J;

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if ({3'd0, rem_in[i]} >= dsh)
                begin
                    rem_reg[k][i]    <= 47'({3'd0, rem_in[i]} - dsh);
                    quo_reg[k][i]    <= quo_in[i] | (QUO_BITS'(1) << J);
                end
                else
                begin
                    rem_reg[k][i]    <= rem_in[i];
                    quo_reg[k][i]    <= quo_in[i];
                end
            end
            d_reg[k]    <= d_in;
            side_reg[k] <= side_in;
        end
    end

    // sign, saturation, identity for a zero product, pass through when off
    always_comb
    begin
        ozrc_side_t          sd;
        logic [QUO_BITS-1:0] r;
        logic signed [17:0]  sv;
        sd = side_reg[QUO_BITS-1];
        for (int i = 0; i < 4; i++)
        begin
            r  = quo_reg[QUO_BITS-1][i];
            sv = sd.neg[i] ? -$signed({1'b0, r}) : $signed({1'b0, r});
            if (!sd.en)
                q_next[i] = sd.pq[i];
            else if (sd.zero)
                q_next[i] = (i == 3) ? 16'h4000 : 16'h0000;
            else
                q_next[i] = sat16(sv);
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        ang_reg <= side_reg[QUO_BITS-1].ang;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld_reg  <= '0;
            vldo_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= in_valid;
            vld_reg  <= {vld_reg[QUO_BITS-2:0], vld0_reg};
            vldo_reg <= vld_reg[QUO_BITS-1];
        end
    end

    assign out_valid = vldo_reg;
    assign q         = q_reg;
    assign ang       = ang_reg;

`ifndef SYNTHESIS
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QUO_BITS-1] && side_reg[QUO_BITS-1].en && !side_reg[QUO_BITS-1].zero
        |-> {3'd0, rem_reg[QUO_BITS-1][0]} < {17'd0, d_reg[QUO_BITS-1]}
            && {3'd0, rem_reg[QUO_BITS-1][3]} < {17'd0, d_reg[QUO_BITS-1]})
        else $error("divider remainder not below divisor");
`endif

endmodule

[hdl/orientation_zero_reference_correct.sv]
// zero reference correction of orientation samples. a sample beat is taken
// whenever start is high (busy is always low), one beat per clock, and its
// result appears on done; done is a one-cycle strobe and the receiver
// cannot stall it, so results must be captured as they come. the pipeline
// is made of the 32-stage square root (one root bit per stage) and the 17-stage
// divider (one quotient bit per stage), plus 2 product stages, 7 scaling
// stages and 2 stages of divider setup and output formatting. configuration is
// written through cfg_wr_en / cfg_index / cfg_data and must only change while
// no sample is in flight.
module orientation_zero_reference_correct
    import ozrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] in_qx,
    input  logic [15:0] in_qy,
    input  logic [15:0] in_qz,
    input  logic [15:0] in_qw,
    input  logic [15:0] in_roll,
    input  logic [15:0] in_pitch,
    input  logic [15:0] in_yaw,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [15:0] out_qx,
    output logic [15:0] out_qy,
    output logic [15:0] out_qz,
    output logic [15:0] out_qw,
    output logic [15:0] out_roll,
    output logic [15:0] out_pitch,
    output logic [15:0] out_yaw
);

    // configuration registers
    logic             zero_enable_reg;
    logic [3:0][15:0] inv_q_reg;
    logic [2:0][15:0] zero_ang_reg;

    // pipeline links
    logic             acc;
    logic             mul_valid;
    logic [3:0][33:0] mul_v;
    ozrc_side_t       mul_side;
    logic             nrm_valid;
    logic [62:0]      nrm_n;
    ozrc_carry_t      nrm_carry;
    logic             sq_valid;
    logic [31:0]      sq_root;
    ozrc_carry_t      sq_carry;
    logic [3:0][15:0] res_q;
    logic [2:0][15:0] res_ang;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_enable_reg <= 1'b0;
            inv_q_reg       <= {16'h4000, 16'h0000, 16'h0000, 16'h0000};
            zero_ang_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ZERO_ENABLE: zero_enable_reg <= cfg_data[0];
                REG_INV_QX:      inv_q_reg[0]    <= cfg_data;
                REG_INV_QY:      inv_q_reg[1]    <= cfg_data;
                REG_INV_QZ:      inv_q_reg[2]    <= cfg_data;
                REG_INV_QW:      inv_q_reg[3]    <= cfg_data;
                REG_ZERO_ROLL:   zero_ang_reg[0] <= cfg_data;
                REG_ZERO_PITCH:  zero_ang_reg[1] <= cfg_data;
                REG_ZERO_YAW:    zero_ang_reg[2] <= cfg_data;
                default:         ;
            endcase
        end
    end

    // fully pipelined with no back pressure, so a beat is never refused
    assign busy = 1'b0;
    assign acc  = start && !busy;

    // stored inverse zero times sample, angle subtraction
    ozrc_qmul u_qmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc),
        .en        (zero_enable_reg),
        .a         (inv_q_reg),
        .b         ({in_qw, in_qz, in_qy, in_qx}),
        .ang       ({in_yaw, in_pitch, in_roll}),
        .zero_ang  (zero_ang_reg),
        .out_valid (mul_valid),
        .v         (mul_v),
        .side      (mul_side)
    );

    // scale into (2^29, 2^30] and form the sum of squares
    ozrc_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .v         (mul_v),
        .side_in   (mul_side),
        .out_valid (nrm_valid),
        .n         (nrm_n),
        .carry     (nrm_carry)
    );

    // floor square root of the norm
    ozrc_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (nrm_valid),
        .n         (nrm_n),
        .carry_in  (nrm_carry),
        .out_valid (sq_valid),
        .root      (sq_root),
        .carry_out (sq_carry)
    );

    // rounded division of each lane by the root, final selection
    ozrc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .s         (sq_root),
        .carry     (sq_carry),
        .out_valid (done),
        .q         (res_q),
        .ang       (res_ang)
    );

    assign out_qx    = res_q[0];
    assign out_qy    = res_q[1];
    assign out_qz    = res_q[2];
    assign out_qw    = res_q[3];
    assign out_roll  = res_ang[0];
    assign out_pitch = res_ang[1];
    assign out_yaw   = res_ang[2];

endmodule

[tb/sv/tb_orientation_zero_reference_correct.sv]
module tb_orientation_zero_reference_correct;
    timeunit 1ns;
    timeprecision 1ps;
    import ozrc_pkg::*;

    // pipeline depth of the block, plus some slack
    localparam int PIPE_DEPTH = 60;
    localparam int SETTLE = PIPE_DEPTH + 10;
    localparam int RANDOM_ITEMS = 1230;
    localparam int CALM_TAIL = 150;
    // an index past the last register, which the block must ignore
    localparam logic [3:0] UNUSED_INDEX = 4'd12;

    typedef struct packed {
        logic [3:0][15:0] q;   // lanes x, y, z, w
        logic [2:0][15:0] a;   // roll, pitch, yaw
    } sample_t;

    // one full register set
    typedef struct {
        logic        en;
        logic [15:0] inv[4];
        logic [15:0] zang[3];
    } zero_ref_t;

    typedef struct {
        int      setting;
        bit      typed;
        sample_t s;
        sample_t r;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] in_qx = '0, in_qy = '0, in_qz = '0, in_qw = '0;
    logic [15:0] in_roll = '0, in_pitch = '0, in_yaw = '0;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        done;
    logic [15:0] out_qx, out_qy, out_qz, out_qw, out_roll, out_pitch, out_yaw;

    orientation_zero_reference_correct dut (.*);

    always #5 clk = ~clk;

    // predictor copy of the registers
    zero_ref_t cur;
    sample_t   pending_results[$];
    int        mismatches = 0;
    row_t      rows[$];
    zero_ref_t presets[3];

    function automatic longint peak_mag(longint v[4]);
        longint m;
        m = 0;
        for (int i = 0; i < 4; i++)
        begin
            if ((v[i] < 0 ? -v[i] : v[i]) > m)
                m = v[i] < 0 ? -v[i] : v[i];
        end
        return m;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // hamilton product with the inverse zero, normalised, angles referenced; sample as is when off
    function automatic sample_t correct_sample(sample_t s);
        sample_t r;
        longint b[4], z[4], v[4];
        longint unsigned n, res, bitv, a, quo;
        if (!cur.en)
            return s;
        for (int i = 0; i < 4; i++)
        begin
            b[i] = longint'($signed(s.q[i]));
            z[i] = longint'($signed(cur.inv[i]));
        end
        v[0] = z[3]*b[0] + z[0]*b[3] + z[1]*b[2] - z[2]*b[1];
        v[1] = z[3]*b[1] - z[0]*b[2] + z[1]*b[3] + z[2]*b[0];
        v[2] = z[3]*b[2] + z[0]*b[1] - z[1]*b[0] + z[2]*b[3];
        v[3] = z[3]*b[3] - z[0]*b[0] - z[1]*b[1] - z[2]*b[2];
        if (peak_mag(v) == 0)
        begin
            r.q[0] = '0;
            r.q[1] = '0;
            r.q[2] = '0;
            r.q[3] = 16'd16384;
        end
        else
        begin
            while (peak_mag(v) > 64'sd1073741824)
                for (int i = 0; i < 4; i++)
                    v[i] = v[i] >>> 1;
            while (peak_mag(v) <= 64'sd536870912)
                for (int i = 0; i < 4; i++)
                    v[i] = v[i] * 2;
            n = 0;
            for (int i = 0; i < 4; i++)
                n += longint'(v[i] * v[i]);
            // floor integer square root
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            for (int i = 0; i < 4; i++)
            begin
                a = v[i] < 0 ? -v[i] : v[i];
                quo = (a * 32768 + res) / (2 * res);
                r.q[i] = clamp16(v[i] < 0 ? -longint'(quo) : longint'(quo));
            end
        end
        for (int i = 0; i < 3; i++)
            r.a[i] = clamp16(longint'($signed(s.a[i])) - longint'($signed(cur.zang[i])));
        return r;
    endfunction

    task automatic report(string field, logic [15:0] got, logic [15:0] want);
        $display("mismatch on %s: got %h, expected %h", field, got, want);
        mismatches++;
    endtask

    // results cannot be held off, so every strobe is checked as it comes
    always @(posedge clk)
    begin
        sample_t got, want;
        if (rst_n && done)
        begin
            got.q = {out_qw, out_qz, out_qy, out_qx};
            got.a = {out_yaw, out_pitch, out_roll};
            if (pending_results.size() == 0)
                report("unexpected beat", got.q[0], '0);
            else
            begin
                want = pending_results.pop_front();
                if (got.q[0] !== want.q[0]) report("out_qx", got.q[0], want.q[0]);
                if (got.q[1] !== want.q[1]) report("out_qy", got.q[1], want.q[1]);
                if (got.q[2] !== want.q[2]) report("out_qz", got.q[2], want.q[2]);
                if (got.q[3] !== want.q[3]) report("out_qw", got.q[3], want.q[3]);
                if (got.a[0] !== want.a[0]) report("out_roll", got.a[0], want.a[0]);
                if (got.a[1] !== want.a[1]) report("out_pitch", got.a[1], want.a[1]);
                if (got.a[2] !== want.a[2]) report("out_yaw", got.a[2], want.a[2]);
            end
        end
    end

    // one register write; the caller lowers the enable after the last one
    task automatic write_reg(logic [3:0] idx, logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_ZERO_ENABLE: cur.en = data[0];
            REG_INV_QX:      cur.inv[0] = data;
            REG_INV_QY:      cur.inv[1] = data;
            REG_INV_QZ:      cur.inv[2] = data;
            REG_INV_QW:      cur.inv[3] = data;
            REG_ZERO_ROLL:   cur.zang[0] = data;
            REG_ZERO_PITCH:  cur.zang[1] = data;
            REG_ZERO_YAW:    cur.zang[2] = data;
            default: ;
        endcase
    endtask

    // wait for the pipe to empty, then let it settle
    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apply_setting(zero_ref_t z);
        start <= 1'b0;
        drain();
        write_reg(UNUSED_INDEX, 16'($urandom));
        write_reg(REG_ZERO_ENABLE, {15'($urandom), z.en});
        write_reg(REG_INV_QX, z.inv[0]);
        write_reg(REG_INV_QY, z.inv[1]);
        write_reg(REG_INV_QZ, z.inv[2]);
        write_reg(REG_INV_QW, z.inv[3]);
        write_reg(REG_ZERO_ROLL, z.zang[0]);
        write_reg(REG_ZERO_PITCH, z.zang[1]);
        write_reg(REG_ZERO_YAW, z.zang[2]);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // one sample beat; start stays high when the next beat follows at once
    task automatic send(sample_t s, bit typed, sample_t r);
        sample_t want;
        start <= 1'b1;
        {in_qw, in_qz, in_qy, in_qx} <= s.q;
        {in_yaw, in_pitch, in_roll} <= s.a;
        @(posedge clk iff !busy);
        want = typed ? r : correct_sample(s);
        pending_results = {pending_results, want};
    endtask

    task automatic idle_burst(bit allowed);
        if (allowed && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic add_row(int setting, bit typed, sample_t s, sample_t r);
        row_t w;
        w.setting = setting;
        w.typed = typed;
        w.s = s;
        w.r = r;
        rows = {rows, w};
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return '0;
            3, 4:    return 16'($signed(5'($urandom)));   // tiny, forces scale-up
            5, 6:    return 16'($signed(15'($urandom)));  // near unit range
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic zero_ref_t rand_setting();
        zero_ref_t z;
        z.en = $urandom_range(0, 3) != 0;
        for (int i = 0; i < 4; i++)
            z.inv[i] = ($urandom_range(0, 9) == 0) ? '0 : rand_comp();
        for (int i = 0; i < 3; i++)
            z.zang[i] = rand_comp();
        return z;
    endfunction

    initial
    begin
        sample_t s, r;
        int setting_now;
        zero_ref_t z;

        cur.en = 1'b0;
        cur.inv = '{16'd0, 16'd0, 16'd0, 16'd16384};
        cur.zang = '{16'd0, 16'd0, 16'd0};

        // preset 0: reset values, pass through
        presets[0] = cur;
        // preset 1: correction on with identity inverse and zero angles
        presets[1] = cur;
        presets[1].en = 1'b1;
        // preset 2: extreme inverse and extreme reference angles
        presets[2].en = 1'b1;
        presets[2].inv = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
        presets[2].zang = '{16'h7fff, 16'h8000, 16'h0001};

        // pass through rows, result equals sample
        s = {64'h7fff7fff7fff7fff, 48'h7fff7fff7fff};
        add_row(0, 1, s, s);
        s = {64'h8000800080008000, 48'h800080008000};
        add_row(0, 1, s, s);
        s = {64'h00017fff8000ffff, 48'h5555aaaa0000};
        add_row(0, 1, s, s);
        // zero sample quaternion gives identity, angles untouched
        s = {64'h0, 48'h12347fff8000};
        r = {64'h4000_0000_0000_0000, 48'h12347fff8000};
        add_row(1, 1, s, r);
        s = {16'h4000, 16'h0, 16'h0, 16'h0, 48'h0};
        add_row(1, 0, s, s);
        s = {16'h0, 16'h0, 16'h0, 16'h4000, 48'h0};
        add_row(1, 0, s, s);
        s = {64'h8000800080008000, 48'h7fff80000001};
        add_row(1, 0, s, s);
        s = {64'h7fff7fff7fff7fff, 48'h0};
        add_row(1, 0, s, s);
        s = {16'hffff, 16'h0, 16'h0, 16'h0001, 48'h0};
        add_row(1, 0, s, s);
        s = {16'h0, 16'h0, 16'h0001, 16'h0, 48'h0};
        add_row(1, 0, s, s);
        // zero quaternion with extreme references: identity, roll and pitch saturate
        s = {64'h0, 48'h0000_7fff_8000};
        r = {64'h4000_0000_0000_0000, 48'hffff_7fff_8000};
        add_row(2, 1, s, r);
        s = {64'h8000800080008000, 48'h7fff7fff7fff};
        add_row(2, 0, s, s);
        s = {64'h7fff80007fff8000, 48'h800080008000};
        add_row(2, 0, s, s);
        s = {64'h0001000100010001, 48'h0};
        add_row(2, 0, s, s);
        s = {16'h2d41, 16'h0, 16'h2d41, 16'h0, 48'h1111};
        add_row(2, 0, s, s);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        setting_now = 0;
        foreach (rows[i])
        begin
            if (rows[i].setting != setting_now)
            begin
                setting_now = rows[i].setting;
                apply_setting(presets[setting_now]);
            end
            send(rows[i].s, rows[i].typed, rows[i].r);
            idle_burst(1);
        end

        // random part, with a fresh register set every so often
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0 && n < RANDOM_ITEMS - CALM_TAIL)
            begin
                z = rand_setting();
                if (n == 300)
                    z.en = 1'b0;
                apply_setting(z);
            end
            // once mid-run, hold off until every result is back
            if (n == 600)
            begin
                start <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            for (int i = 0; i < 4; i++)
                s.q[i] = rand_comp();
            if ($urandom_range(0, 19) == 0)
                s.q = '0;
            for (int i = 0; i < 3; i++)
                s.a[i] = rand_comp();
            send(s, 0, s);
            idle_burst(n < RANDOM_ITEMS - CALM_TAIL);
        end
        start <= 1'b0;
        drain();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // overall watchdog
    initial
    begin
        #3ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
